// ===== src/oof_pkg.sv =====
// shared constants, types and pointer helpers of the overwrite-oldest event fifo
package oof_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int PTR_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int CONF_W   = 16;
    localparam int CFG_W    = 7;
    localparam int LIMIT_W  = 7;
    localparam int OCC_W    = 7;
    localparam int STATUS_W = 2;
    localparam int OVF_W    = 32;
    localparam int ENTRY_W  = TIME_W + CONF_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERWRITE = 2'd1,
        STATUS_REFUSED   = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // advance a ring pointer, wrapping at the capacity in use
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] sum;
        begin
            sum = CNT_W'(p) + CNT_W'(1);
            return (sum >= cap) ? '0 : sum[PTR_W-1:0];
        end
    endfunction

    // zero or oversized capacity means the full ring
    function automatic logic [CNT_W-1:0] eff_capacity(input logic [CFG_W-1:0] c);
        begin
            if (c == '0 || c > CFG_W'(MAX_ENTRIES))
                return CNT_W'(MAX_ENTRIES);
            else
                return c[CNT_W-1:0];
        end
    endfunction

endpackage

// ===== src/overwrite_oldest_event_fifo.sv =====
// top level of the overwrite-oldest event fifo: control, pointers and result register
// a command beat is captured and executed in S_EXEC; its result beat is registered once
//   the result register is free; no new command is taken until S_EXEC is left, and a peek
//   sends its entries one per cycle while the result side does not stall
// reset: pointers, occupancy, overflow counter and capacity (full ring) clear at once
//   on rst_n low; entry ram contents stay undefined until written, no clearing pass
module overwrite_oldest_event_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write
    input  logic                          cfg_write,
    input  logic [oof_pkg::CFG_W-1:0]     capacity_in_use,
    // command channel
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  logic [oof_pkg::OP_W-1:0]      operation,
    input  logic [oof_pkg::TIME_W-1:0]    event_time,
    input  logic [oof_pkg::CONF_W-1:0]    event_confidence,
    input  logic [oof_pkg::LIMIT_W-1:0]   peek_limit,
    // result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [oof_pkg::STATUS_W-1:0]  status,
    output logic [oof_pkg::TIME_W-1:0]    out_time,
    output logic [oof_pkg::CONF_W-1:0]    out_confidence,
    output logic                          run_end,
    output logic [oof_pkg::OCC_W-1:0]     occupancy,
    output logic [oof_pkg::OVF_W-1:0]     overflow_total
);

    import oof_pkg::*;

    // control state
    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [PTR_W-1:0]   scan_reg, scan_next;     // slot whose data sits on the ram output
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]   cap_reg, cap_next;
    logic [CNT_W-1:0]   count_reg, count_next;   // peek beats already sent
    logic [OVF_W-1:0]   ovf_reg, ovf_next;
    logic               res_valid_reg, res_valid_next;

    // captured command, payload only
    logic [OP_W-1:0]    op_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [CONF_W-1:0]  conf_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // result payload
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TIME_W-1:0]   otime_reg, otime_next;
    logic [CONF_W-1:0]   oconf_reg, oconf_next;
    logic                run_end_reg, run_end_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OVF_W-1:0]    ovf_out_reg, ovf_out_next;

    // ram side
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic               cmd_accept;
    logic               out_free;
    logic               emit;
    logic               peek_last;
    logic [CNT_W-1:0]   peek_n;

    // commands are taken only while nothing is in flight
    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // result register can take a new beat when empty or being drained
    assign out_free = !res_valid_reg || !res_stall;

    // peek length is the smaller of occupancy and the limit
    always_comb
    begin
        if (OCC_W'(held_reg) < limit_reg)
            peek_n = held_reg;
        else
            peek_n = limit_reg[CNT_W-1:0];
    end

    assign peek_last = ((count_reg + CNT_W'(1)) == peek_n);

    oof_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data ({time_reg, conf_reg}),
        .rd_addr (scan_next),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            scan_reg      <= '0;
            held_reg      <= '0;
            cap_reg       <= eff_capacity(CFG_W'(MAX_ENTRIES));
            count_reg     <= '0;
            ovf_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            scan_reg      <= scan_next;
            held_reg      <= held_next;
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            op_reg    <= operation;
            time_reg  <= event_time;
            conf_reg  <= event_confidence;
            limit_reg <= peek_limit;
        end
        status_reg  <= status_next;
        otime_reg   <= otime_next;
        oconf_reg   <= oconf_next;
        run_end_reg <= run_end_next;
        occ_reg     <= occ_next;
        ovf_out_reg <= ovf_out_next;
    end

    // next state, pointer updates and result beat
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        held_next      = held_reg;
        cap_next       = cap_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg && res_stall;
        status_next    = status_reg;
        otime_next     = otime_reg;
        oconf_next     = oconf_reg;
        run_end_next   = run_end_reg;
        occ_next       = occ_reg;
        ovf_out_next   = ovf_out_reg;
        ram_we         = 1'b0;
        emit           = 1'b0;
        scan_next      = rp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = S_EXEC;
                    count_next = '0;
                end
            end
            S_EXEC:
            begin
                // a stalled peek keeps rereading the same slot
                if (op_t'(op_reg) == OP_PEEK)
                    scan_next = scan_reg;
                if (out_free)
                begin
                    emit         = 1'b1;
                    state_next   = S_IDLE;
                    status_next  = STATUS_DONE;
                    otime_next   = '0;
                    oconf_next   = '0;
                    run_end_next = 1'b1;
                    case (op_t'(op_reg))
                        OP_PUSH:
                        begin
                            if (time_reg == '0)
                            begin
                                status_next = STATUS_REFUSED;
                            end
                            else
                            begin
                                ram_we  = 1'b1;
                                wp_next = next_slot(wp_reg, cap_reg);
                                if (held_reg < cap_reg)
                                begin
                                    held_next = held_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    // ring full: oldest entry is dropped
                                    rp_next     = next_slot(rp_reg, cap_reg);
                                    ovf_next    = ovf_reg + OVF_W'(1);
                                    status_next = STATUS_OVERWRITE;
                                end
                            end
                        end
                        OP_POP:
                        begin
                            if (held_reg == '0)
                            begin
                                status_next = STATUS_REFUSED;
                            end
                            else
                            begin
                                otime_next = ram_rd_data[ENTRY_W-1:CONF_W];
                                oconf_next = ram_rd_data[CONF_W-1:0];
                                rp_next    = next_slot(rp_reg, cap_reg);
                                held_next  = held_reg - CNT_W'(1);
                            end
                        end
                        OP_PEEK:
                        begin
                            if (peek_n == '0)
                            begin
                                status_next = STATUS_REFUSED;
                                scan_next   = rp_reg;
                            end
                            else
                            begin
                                otime_next   = ram_rd_data[ENTRY_W-1:CONF_W];
                                oconf_next   = ram_rd_data[CONF_W-1:0];
                                run_end_next = peek_last;
                                if (peek_last)
                                begin
                                    scan_next = rp_reg;
                                end
                                else
                                begin
                                    state_next = S_EXEC;
                                    count_next = count_reg + CNT_W'(1);
                                    scan_next  = next_slot(scan_reg, cap_reg);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            wp_next   = '0;
                            rp_next   = '0;
                            held_next = '0;
                        end
                        default:
                        begin
                            status_next = STATUS_REFUSED;
                        end
                    endcase
                    if (op_t'(op_reg) != OP_PEEK)
                        scan_next = rp_next;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            res_valid_next = 1'b1;
            occ_next       = OCC_W'(held_next);
            ovf_out_next   = ovf_next;
        end

        // capacity write empties the ring, overflow count is kept
        if (cfg_write)
        begin
            cap_next  = eff_capacity(capacity_in_use);
            wp_next   = '0;
            rp_next   = '0;
            held_next = '0;
            scan_next = '0;
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign out_time       = otime_reg;
    assign out_confidence = oconf_reg;
    assign run_end        = run_end_reg;
    assign occupancy      = occ_reg;
    assign overflow_total = ovf_out_reg;

    // pointers and occupancy stay inside the ring in use
    a_ring_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(rp_reg) < cap_reg) && (CNT_W'(wp_reg) < cap_reg) && (held_reg <= cap_reg))
        else $error("ring pointer or occupancy outside capacity");

    // between commands the ram read address tracks the oldest entry
    a_scan_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (scan_reg == rp_reg))
        else $error("read address not at oldest entry while idle");

    // a refused beat is always the last beat and carries no entry
    a_refused_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (status_reg == STATUS_REFUSED))
            |-> (run_end_reg && (otime_reg == '0) && (oconf_reg == '0)))
        else $error("refused beat with entry data or not last");

    // a push that overwrote leaves the ring full
    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && out_free && !cfg_write && status_next == STATUS_OVERWRITE
            && op_t'(op_reg) == OP_PUSH) |=> (held_reg == cap_reg))
        else $error("overwrite without full ring");

endmodule

// ===== src/oof_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module oof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the overwrite-oldest event fifo: directed and random command beats

module tb;
    import oof_pkg::*;

    // random part: one ring size per phase, the beats sent in it and the share of pushes
    localparam int NUM_PHASES = 8;
    localparam int PHASE_BEATS [NUM_PHASES] = '{40, 25, 95, 20, 25, 20, 45, 40};
    localparam int PHASE_PUSH_PCT [NUM_PHASES] = '{45, 45, 85, 60, 60, 60, 50, 55};
    // phase with neither command gaps nor result stalls
    localparam int STEADY_PHASE = 2;

    // one result beat as the fifo should present it
    typedef struct {
        status_t             status;
        logic [TIME_W-1:0]   ev_time;
        logic [CONF_W-1:0]   confidence;
        logic                last;
        logic [OCC_W-1:0]    held_after;
        logic [OVF_W-1:0]    overwrites_after;
    } fifo_reply_t;

    // mirror of the ring plus the queue of result beats still owed by the fifo
    class event_fifo_scoreboard;
        logic [ENTRY_W-1:0] ring [MAX_ENTRIES];
        logic [PTR_W-1:0]   wr_ptr;
        logic [PTR_W-1:0]   rd_ptr;
        logic [CNT_W-1:0]   held;
        logic [OVF_W-1:0]   overwrites;
        logic [CFG_W-1:0]   capacity_reg;
        fifo_reply_t        replies_due [$];
        int                 failures;

        function new();
            wr_ptr = '0;
            rd_ptr = '0;
            held = '0;
            overwrites = '0;
            capacity_reg = CFG_W'(MAX_ENTRIES);
            failures = 0;
        endfunction

        // zero or oversized register value means the whole ring
        function logic [CNT_W-1:0] ring_size();
            if (capacity_reg == '0 || capacity_reg > CFG_W'(MAX_ENTRIES))
                return CNT_W'(MAX_ENTRIES);
            return capacity_reg[CNT_W-1:0];
        endfunction

        function logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p, logic [CNT_W-1:0] size);
            logic [CNT_W-1:0] sum;
            sum = CNT_W'(p) + CNT_W'(1);
            return (sum >= size) ? '0 : sum[PTR_W-1:0];
        endfunction

        // a capacity write also empties the ring, overwrite count kept
        function void set_capacity(logic [CFG_W-1:0] value);
            capacity_reg = value;
            wr_ptr = '0;
            rd_ptr = '0;
            held = '0;
        endfunction

        function void owe_reply(status_t st, logic [ENTRY_W-1:0] entry, logic last);
            fifo_reply_t r;
            r.status = st;
            r.ev_time = entry[ENTRY_W-1:CONF_W];
            r.confidence = entry[CONF_W-1:0];
            r.last = last;
            r.held_after = held;
            r.overwrites_after = overwrites;
            replies_due.push_back(r);
        endfunction

        // update the mirror for one accepted command and queue what it must produce
        function void apply_command(op_t op, logic [TIME_W-1:0] t, logic [CONF_W-1:0] conf,
                                    logic [LIMIT_W-1:0] limit);
            logic [CNT_W-1:0] size;
            logic [PTR_W-1:0] wp;
            logic [PTR_W-1:0] rp;
            logic [CNT_W-1:0] n;
            logic [ENTRY_W-1:0] entry;
            status_t st;
            size = ring_size();
            wp = (CNT_W'(wr_ptr) < size) ? wr_ptr : '0;
            rp = (CNT_W'(rd_ptr) < size) ? rd_ptr : '0;
            case (op)
                OP_PUSH:
                begin
                    if (t == '0)
                    begin
                        owe_reply(STATUS_REFUSED, '0, 1'b1);
                        return;
                    end
                    st = STATUS_DONE;
                    ring[wp] = {t, conf};
                    wr_ptr = advance(wp, size);
                    if (held < size)
                    begin
                        held = held + CNT_W'(1);
                        rd_ptr = rp;
                    end
                    else
                    begin
                        rd_ptr = advance(rp, size);
                        overwrites = overwrites + OVF_W'(1);
                        st = STATUS_OVERWRITE;
                    end
                    owe_reply(st, '0, 1'b1);
                end
                OP_POP:
                begin
                    if (held == '0)
                    begin
                        owe_reply(STATUS_REFUSED, '0, 1'b1);
                        return;
                    end
                    entry = ring[rp];
                    rd_ptr = advance(rp, size);
                    held = held - CNT_W'(1);
                    owe_reply(STATUS_DONE, entry, 1'b1);
                end
                OP_PEEK:
                begin
                    n = (held < CNT_W'(limit)) ? held : CNT_W'(limit);
                    if (n == '0)
                    begin
                        owe_reply(STATUS_REFUSED, '0, 1'b1);
                        return;
                    end
                    for (int i = 0; i < int'(n); i++)
                    begin
                        owe_reply(STATUS_DONE, ring[rp], (i + 1 == int'(n)));
                        rp = advance(rp, size);
                    end
                end
                default:
                begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                    held = '0;
                    owe_reply(STATUS_DONE, '0, 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                failures++;
            end
        endfunction

        // one accepted result beat against the oldest owed reply
        function void check_reply(logic [STATUS_W-1:0] st, logic [TIME_W-1:0] t,
                                  logic [CONF_W-1:0] conf, logic last,
                                  logic [OCC_W-1:0] occ, logic [OVF_W-1:0] ovf);
            fifo_reply_t want;
            if (replies_due.size() == 0)
            begin
                $display(
                    "%0t: result beat with nothing owed, expected none actual status %0h time %0h",
                    $time, st, t);
                failures++;
                return;
            end
            want = replies_due.pop_front();
            compare_field("status", 32'(want.status), 32'(st));
            compare_field("out_time", want.ev_time, t);
            compare_field("out_confidence", 32'(want.confidence), 32'(conf));
            compare_field("run_end", 32'(want.last), 32'(last));
            compare_field("occupancy", 32'(want.held_after), 32'(occ));
            compare_field("overflow_total", want.overwrites_after, ovf);
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    // every block input starts at a known value
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_W-1:0]      capacity_in_use = '0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    op_t                   operation = OP_PUSH;
    logic [TIME_W-1:0]     event_time = '0;
    logic [CONF_W-1:0]     event_confidence = '0;
    logic [LIMIT_W-1:0]    peek_limit = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [TIME_W-1:0]     out_time;
    logic [CONF_W-1:0]     out_confidence;
    logic                  run_end;
    logic [OCC_W-1:0]      occupancy;
    logic [OVF_W-1:0]      overflow_total;

    // set during the steady phase: no command gaps, no result stalls
    logic steady_run = 1'b0;

    event_fifo_scoreboard fifo_sb = new();

    overwrite_oldest_event_fifo dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .capacity_in_use  (capacity_in_use),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .operation        (operation),
        .event_time       (event_time),
        .event_confidence (event_confidence),
        .peek_limit       (peek_limit),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .status           (status),
        .out_time         (out_time),
        .out_confidence   (out_confidence),
        .run_end          (run_end),
        .occupancy        (occupancy),
        .overflow_total   (overflow_total)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side back-pressure, raised with a chance of roughly 8 in a hundred
    always @(posedge clk)
        res_stall <= !steady_run && ($urandom_range(99) < 8);

    // result beats are checked as they are taken, values seen before the edge
    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            fifo_sb.check_reply(status, out_time, out_confidence, run_end, occupancy,
                                overflow_total);

    // present one command beat, hold it until taken, then maybe leave a gap
    task automatic send_command(op_t op, logic [TIME_W-1:0] t, logic [CONF_W-1:0] conf,
                                logic [LIMIT_W-1:0] limit);
        cmd_valid <= 1'b1;
        operation <= op;
        event_time <= t;
        event_confidence <= conf;
        peek_limit <= limit;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        fifo_sb.apply_command(op, t, conf, limit);
        // valid is only dropped here, so no step sees it lowered and raised again
        if (!steady_run && $urandom_range(99) < 8)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // stop sending and wait until every owed result beat has come back
    task automatic drain_fifo();
        cmd_valid <= 1'b0;
        while (fifo_sb.pending() != 0)
            @(posedge clk);
        // the fifo may still be finishing its last command cycle
        repeat (4) @(posedge clk);
    endtask

    // only called with the fifo idle
    task automatic write_capacity(logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        capacity_in_use <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        fifo_sb.set_capacity(value);
    endtask

    // random command: pushes at the given share so the ring fills and wraps, plus pops, peeks,
    // clears and the odd zero-time push
    task automatic random_command(int push_pct);
        op_t                op;
        logic [TIME_W-1:0]  t;
        logic [CONF_W-1:0]  conf;
        logic [LIMIT_W-1:0] limit;
        int                 pick;
        t = $urandom;
        conf = CONF_W'($urandom);
        limit = LIMIT_W'($urandom_range(8));
        // now and then a limit over the whole field
        if ($urandom_range(9) == 0)
            limit = LIMIT_W'($urandom_range(127));
        pick = $urandom_range(99);
        if (pick < push_pct)
        begin
            op = OP_PUSH;
            if ($urandom_range(19) == 0)
                t = '0;
        end
        else
        begin
            pick = $urandom_range(19);
            if (pick < 9)
                op = OP_POP;
            else if (pick < 18)
                op = OP_PEEK;
            else
                op = OP_CLEAR;
        end
        send_command(op, t, conf, limit);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_cap [NUM_PHASES];
        // full ring in all its spellings, tiny rings and random sizes
        phase_cap = '{7'd3, 7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd0, 7'd0};
        phase_cap[6] = CFG_W'($urandom_range(2, 16));
        phase_cap[7] = CFG_W'($urandom_range(1, 127));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset ring size: empty-ring corner cases first
        send_command(OP_PUSH, 32'h0, 16'hFFFF, 7'd0);          // zero time refused
        send_command(OP_POP, 32'hFFFF_FFFF, 16'hFFFF, 7'd127); // pop of empty ring
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd5);             // peek of empty ring
        send_command(OP_CLEAR, 32'h0, 16'h0, 7'd0);
        send_command(OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 7'd127);
        send_command(OP_PUSH, 32'h1, 16'h0, 7'd0);
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd0);             // zero limit
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd127);           // limit above occupancy
        send_command(OP_POP, 32'h0, 16'h0, 7'd0);
        send_command(OP_POP, 32'h0, 16'h0, 7'd0);
        send_command(OP_POP, 32'h0, 16'h0, 7'd0);

        // two-entry ring: wrap and overwrite of the oldest
        drain_fifo();
        write_capacity(7'd2);
        send_command(OP_PUSH, 32'h0000_00A1, 16'h1111, 7'd0);
        send_command(OP_PUSH, 32'h0000_00B2, 16'h2222, 7'd0);
        send_command(OP_PUSH, 32'h8000_00C3, 16'h3333, 7'd0);
        send_command(OP_PUSH, 32'h4000_00D4, 16'h8444, 7'd0);
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd64);
        send_command(OP_POP, 32'h0, 16'h0, 7'd0);
        send_command(OP_CLEAR, 32'h0, 16'h0, 7'd0);
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd3);
        send_command(OP_PUSH, 32'h0000_00E5, 16'h5555, 7'd0);
        send_command(OP_PEEK, 32'h0, 16'h0, 7'd1);

        // random phases, each after a drain and a new ring size; the drain is also
        // the point where the sender holds off until nothing is owed
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_fifo();
            steady_run = (p == STEADY_PHASE);
            write_capacity(phase_cap[p]);
            repeat (PHASE_BEATS[p]) random_command(PHASE_PUSH_PCT[p]);
        end

        drain_fifo();
        steady_run = 1'b0;
        // room for any stray result beat to show up
        repeat (16) @(posedge clk);
        if (fifo_sb.failures == 0)
            $display("PASS overwrite_oldest_event_fifo");
        else
            $display("FAIL overwrite_oldest_event_fifo");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("FAIL overwrite_oldest_event_fifo");
        $finish;
    end

endmodule

// ===== files.f =====
src/oof_pkg.sv
src/oof_ram.sv
src/overwrite_oldest_event_fifo.sv
verif/tb.sv
